>>> hdl/bitmap_block_allocator_core_macros.svh
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`ifndef SYNTHESIS
`define BBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");
`else
`define BBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

// next-cycle implication
`ifndef SYNTHESIS
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap allocator sequencing check failed");
`else
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/bba_pkg.sv
// shared types, codes and widths of the bitmap block allocator
package bba_pkg;

  localparam int ADDR_BITS      = 32;
  localparam int BSIZE_W        = 17;
  localparam int BCOUNT_W       = 7;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int GROUP_BITS     = 8;
  localparam int DEF_MAX_BLOCKS = 64;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  // register reset values
  localparam logic [ADDR_BITS-1:0] RST_HEAP_BASE   = '0;
  localparam logic [BSIZE_W-1:0]   RST_BLOCK_SIZE  = 17'd64;
  localparam logic [BCOUNT_W-1:0]  RST_BLOCK_COUNT = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_SCAN,
    S_MUL,
    S_ADDR,
    S_DIV,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic check;
    logic div_start;
    logic scan;
    logic mul;
    logic addr;
    logic clear;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic inside_now;
    logic found;
    logic scan_last;
    logic div_done;
  } sts_t;

endpackage

>>> hdl/bba_in_if.sv
// request channel: operation and address
interface bba_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [bba_pkg::ADDR_BITS-1:0] address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

>>> hdl/bba_out_if.sv
// result channel: status, block address and region flag
interface bba_out_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::ADDR_BITS-1:0] block_address;
  logic                          in_region;

  modport source (output valid, status, block_address, in_region, input ready);
  modport sink   (input valid, status, block_address, in_region, output ready);
endinterface

>>> hdl/bba_div.sv
// restoring divider, one quotient bit per cycle, for a quotient known to fit QB bits
module bba_div #(
  parameter int QB = 6,
  parameter int RW = 32,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [RW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QB-1:0] quotient
);

  localparam int SBW = (QB > 1) ? $clog2(QB) : 1;

  logic [RW-1:0]  rem_r, rem_nxt;
  logic [RW-1:0]  dsh_r, dsh_nxt;
  logic [QB-1:0]  quo_r, quo_nxt;
  logic [SBW-1:0] step_r, step_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           fits;

  // trial subtract of the shifted divisor
  assign fits = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dsh_nxt  = RW'(divisor) << (QB - 1);
      quo_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt  = QB'({quo_r, fits});
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r + SBW'(1);
      if (step_r == SBW'(QB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/bba_ctrl.sv
// sequencer of the bitmap block allocator
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  bba_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // output register can take a new result
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bba_pkg::S_PREP;
      end
      bba_pkg::S_PREP: begin
        state_nxt = bba_pkg::S_CHECK;
      end
      bba_pkg::S_CHECK: begin
        if (!sts.is_free) state_nxt = bba_pkg::S_SCAN;
        else if (sts.inside_now) state_nxt = bba_pkg::S_DIV;
        else state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_SCAN: begin
        if (sts.found) state_nxt = bba_pkg::S_MUL;
        else if (sts.scan_last) state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_MUL: begin
        state_nxt = bba_pkg::S_ADDR;
      end
      bba_pkg::S_ADDR: begin
        state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (out_free) state_nxt = bba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      bba_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      bba_pkg::S_PREP: begin
        cmd.prep = 1'b1;
      end
      bba_pkg::S_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = sts.is_free && sts.inside_now;
      end
      bba_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      bba_pkg::S_MUL: begin
        cmd.mul = 1'b1;
      end
      bba_pkg::S_ADDR: begin
        cmd.addr = 1'b1;
      end
      bba_pkg::S_DIV: begin
        cmd.clear = sts.div_done;
      end
      bba_pkg::S_DONE: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/bba_dp.sv
// datapath: registers, used map, group scan, multiply and divider
module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_operation,
  input  logic [bba_pkg::ADDR_BITS-1:0]   in_address,
  input  bba_pkg::cmd_t                   cmd,
  output bba_pkg::sts_t                   sts,
  output logic [bba_pkg::STATUS_W-1:0]    out_status,
  output logic [bba_pkg::ADDR_BITS-1:0]   out_block_address,
  output logic                            out_in_region
);

  localparam int AW  = bba_pkg::ADDR_BITS;
  localparam int BW  = bba_pkg::BSIZE_W;
  localparam int NW  = bba_pkg::BCOUNT_W;
  localparam int GB  = bba_pkg::GROUP_BITS;
  localparam int GSH = $clog2(GB);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int QB  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NG  = (MAX_BLOCKS + GB - 1) / GB;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW  = GW + GSH;
  localparam int SW  = BW + CW;
  localparam int RW  = (SW > AW) ? SW : AW;
  localparam int CPW = ((PW > CW) ? PW : CW) + 1;
  localparam int MW  = QB + BW;

  // configuration registers
  logic [AW-1:0] base_r;
  logic [BW-1:0] bsize_r;
  logic [NW-1:0] bcount_r;

  // used map, one bit per block
  logic [MAX_BLOCKS-1:0] used_r, used_nxt;

  // item registers
  logic                       op_r;
  logic [AW-1:0]              addr_r;
  logic [AW-1:0]              offset_r;
  logic                       ge_r;
  logic [SW-1:0]              size_r;
  logic                       inside_r;
  logic [GW-1:0]              grp_r;
  logic [QB-1:0]              idx_r;
  logic [MW-1:0]              prod_r;
  logic [bba_pkg::STATUS_W-1:0] res_status_r;
  logic [AW-1:0]              res_baddr_r;
  logic [bba_pkg::STATUS_W-1:0] out_status_r;
  logic [AW-1:0]              out_baddr_r;
  logic                       out_region_r;

  logic [CW-1:0]      n_cur;
  logic [CW-1:0]      n_new;
  logic               inside_now;
  logic [NG*GB-1:0]   used_pad;
  logic [GB-1:0]      grp_word;
  logic [GB-1:0]      avail;
  logic               found;
  logic [GSH-1:0]     jsel;
  logic               scan_last;
  logic [QB-1:0]      idx_found;
  logic               div_done;
  logic [QB-1:0]      quotient;

  // block count saturated at the map size
  function automatic logic [CW-1:0] sat_count(input logic [NW-1:0] c);
    logic [CW-1:0] r;
    if (int'(c) > MAX_BLOCKS) r = CW'(MAX_BLOCKS);
    else r = CW'(c);
    return r;
  endfunction

  assign n_cur = sat_count(bcount_r);
  assign n_new = sat_count(cfg_data[NW-1:0]);

  // membership test against the registered size
  assign inside_now = ge_r && (RW'(offset_r) < RW'(size_r));

  // one group of map bits per scan step
  assign used_pad = (NG*GB)'(used_r);
  assign grp_word = used_pad[{grp_r, GSH'(0)} +: GB];

  always_comb begin
    for (int j = 0; j < GB; j++) begin
      avail[j] = !grp_word[j] && (CPW'({grp_r, GSH'(j)}) < CPW'(n_cur));
    end
  end

  // lowest free bit in the group
  always_comb begin
    found = 1'b0;
    jsel  = '0;
    for (int j = GB - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        jsel  = GSH'(j);
      end
    end
  end

  assign scan_last = (grp_r == GW'(NG - 1)) ||
                     (CPW'({grp_r, GSH'(0)}) + CPW'(GB) >= CPW'(n_cur));
  assign idx_found = QB'({grp_r, jsel});

  // used map update: resize clear, allocate set, free clear
  always_comb begin
    used_nxt = used_r;
    if (cfg_we && cfg_index == bba_pkg::REG_BLOCK_COUNT) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (i >= int'(n_new)) used_nxt[i] = 1'b0;
      end
    end
    if (cmd.scan && found) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (i == int'(idx_found)) used_nxt[i] = 1'b1;
      end
    end
    if (cmd.clear) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (i == int'(quotient)) used_nxt[i] = 1'b0;
      end
    end
  end

  // configuration and map state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= bba_pkg::RST_HEAP_BASE;
      bsize_r  <= bba_pkg::RST_BLOCK_SIZE;
      bcount_r <= bba_pkg::RST_BLOCK_COUNT;
      used_r   <= '0;
    end else begin
      used_r <= used_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bba_pkg::REG_HEAP_BASE:   base_r   <= cfg_data[AW-1:0];
          bba_pkg::REG_BLOCK_SIZE:  bsize_r  <= cfg_data[BW-1:0];
          bba_pkg::REG_BLOCK_COUNT: bcount_r <= cfg_data[NW-1:0];
          default: ;
        endcase
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      addr_r <= in_address;
    end
    if (cmd.prep) begin
      size_r   <= SW'(bsize_r) * SW'(n_cur);
      offset_r <= addr_r - base_r;
      ge_r     <= (addr_r >= base_r);
      grp_r    <= '0;
    end
    if (cmd.check) begin
      inside_r    <= inside_now;
      res_baddr_r <= '0;
      if (op_r == bba_pkg::OP_FREE && !inside_now) res_status_r <= bba_pkg::ST_OUTSIDE;
      else res_status_r <= bba_pkg::ST_DONE;
    end
    if (cmd.scan) begin
      if (found) idx_r <= idx_found;
      else if (scan_last) res_status_r <= bba_pkg::ST_NO_FREE;
      else grp_r <= grp_r + GW'(1);
    end
    if (cmd.mul) begin
      prod_r <= MW'(idx_r) * MW'(bsize_r);
    end
    if (cmd.addr) begin
      res_baddr_r <= base_r + AW'(prod_r);
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_baddr_r  <= res_baddr_r;
      out_region_r <= inside_r;
    end
  end

  // offset divided by block size gives the block index
  bba_div #(
    .QB (QB),
    .RW (RW),
    .DW (BW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (RW'(offset_r)),
    .divisor  (bsize_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.is_free    = (op_r == bba_pkg::OP_FREE);
  assign sts.inside_now = inside_now;
  assign sts.found      = found;
  assign sts.scan_last  = scan_last;
  assign sts.div_done   = div_done;

  assign out_status        = out_status_r;
  assign out_block_address = out_baddr_r;
  assign out_in_region     = out_region_r;

endmodule

>>> hdl/bitmap_block_allocator_core.sv
// top level of the bitmap block allocator
//
//   channel  | direction | beat contents
//   ---------+-----------+-------------------------------------------
//   in_bus   | in        | operation, address
//   out_bus  | out       | status, block_address, in_region
//   cfg_*    | in        | write enable, register index, write data
//
// one item at a time; an allocate scans the used map in groups of
// eight map bits, up to ceil(MAX_BLOCKS/8) groups, and stops at the first free bit
// a free inside the region finds its block index with the one-bit-per-cycle divider
// the next request is taken while the last result still waits in the output register
// a stalled result holds the sequencer in its final state until out_bus is ready
// synchronous active-low reset frees every block and loads the register defaults
`include "bitmap_block_allocator_core_macros.svh"

module bitmap_block_allocator_core #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bba_in_if.sink                         in_bus,
  bba_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  // sequencer
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_bus.operation),
    .in_address        (in_bus.address),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_bus.status),
    .out_block_address (out_bus.block_address),
    .out_in_region     (out_bus.in_region)
  );

  // checks
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_bus.valid && in_bus.ready, !in_bus.ready)
  `BBA_ASSERT_IMPLIES(a_no_free_zero_addr, clk, rst_n, out_bus.valid && out_bus.status == bba_pkg::ST_NO_FREE, out_bus.block_address == '0)
  `BBA_ASSERT_IMPLIES(a_outside_not_in_region, clk, rst_n, out_bus.valid && out_bus.status == bba_pkg::ST_OUTSIDE, !out_bus.in_region)

endmodule

>>> test/bitmap_block_allocator_core_test.sv
// testbench for the bitmap block allocator: directed corners, resize, random settings, backpressure
module bitmap_block_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned MAX_LOGGED      = 40;
  localparam int unsigned PHASE_ITEMS     = 140;

  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [ADDR_BITS-1:0] block_address;
    logic                 in_region;
    int unsigned          seq;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bba_in_if  in_bus ();
  bba_out_if out_bus ();

  bitmap_block_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the allocator state and registers
  logic [DEF_MAX_BLOCKS-1:0] used_bits;
  logic [ADDR_BITS-1:0]      base_addr;
  logic [BSIZE_W-1:0]        blk_size;
  logic [BCOUNT_W-1:0]       blk_count;

  reply_t      replies_in_flight[$];
  int unsigned request_seq;
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          idle_enable;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_LOGGED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic int unsigned live_blocks();
    return (blk_count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(blk_count);
  endfunction

  function automatic logic [63:0] region_span();
    return 64'(blk_size) * 64'(live_blocks());
  endfunction

  // allocate the lowest free block or release the block holding addr
  function automatic reply_t apply_request(input logic op, input logic [ADDR_BITS-1:0] addr);
    reply_t      r;
    int unsigned n;
    int unsigned idx;
    logic [63:0] offset;
    logic        found;
    n = live_blocks();
    offset = 64'(addr) - 64'(base_addr);
    r.in_region = (addr >= base_addr) && (offset < region_span());
    r.status = ST_DONE;
    r.block_address = '0;
    r.seq = 0;
    if (op == OP_ALLOC) begin
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!found && !used_bits[i]) begin
          found = 1'b1;
          used_bits[i] = 1'b1;
          r.block_address = base_addr + ADDR_BITS'(i) * ADDR_BITS'(blk_size);
        end
      end
      if (!found) r.status = ST_NO_FREE;
    end else if (r.in_region) begin
      idx = int'(offset / 64'(blk_size));
      used_bits[idx] = 1'b0;
    end else begin
      r.status = ST_OUTSIDE;
    end
    return r;
  endfunction

  // in half the draws an address inside a block, preferring taken ones; else region edges and noise
  function automatic logic [ADDR_BITS-1:0] pick_address();
    int unsigned          n;
    int unsigned          idx;
    logic [63:0]          span;
    logic [ADDR_BITS-1:0] addr;
    n = live_blocks();
    span = region_span();
    addr = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (n != 0) begin
          idx = $urandom_range(0, n - 1);
          for (int t = 0; t < 8 && !used_bits[idx]; t++) idx = $urandom_range(0, n - 1);
          addr = base_addr + ADDR_BITS'(idx) * ADDR_BITS'(blk_size);
          if (blk_size != 0) addr = addr + ADDR_BITS'($urandom_range(0, blk_size - 1));
        end
      end
      5: addr = base_addr + span[ADDR_BITS-1:0] - 1;
      6: addr = base_addr + span[ADDR_BITS-1:0];
      7: addr = base_addr - 1;
      8: addr = base_addr;
      default: ;
    endcase
    return addr;
  endfunction

  // one request beat; the expected reply is computed when it is taken
  task automatic offer_request(input logic op, input logic [ADDR_BITS-1:0] addr);
    int unsigned gap;
    reply_t      r;
    gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.address   <= addr;
    do @(posedge clk); while (!in_bus.ready);
    r = apply_request(op, addr);
    r.seq = request_seq;
    request_seq++;
    replies_in_flight.push_back(r);
  endtask

  // stop offering and wait for every reply
  task automatic drain_replies();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (replies_in_flight.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_HEAP_BASE:   base_addr = data[ADDR_BITS-1:0];
      REG_BLOCK_SIZE:  blk_size = data[BSIZE_W-1:0];
      REG_BLOCK_COUNT: begin
        blk_count = data[BCOUNT_W-1:0];
        for (int i = live_blocks(); i < DEF_MAX_BLOCKS; i++) used_bits[i] = 1'b0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] size,
                           input logic [CFG_DATA_W-1:0] count);
    drain_replies();
    write_register(REG_HEAP_BASE, base);
    write_register(REG_BLOCK_SIZE, size);
    write_register(REG_BLOCK_COUNT, count);
  endtask

  task automatic run_traffic(input int unsigned count, input int unsigned free_pct);
    logic                 op;
    logic [ADDR_BITS-1:0] addr;
    repeat (count) begin
      op = ($urandom_range(0, 99) < free_pct) ? OP_FREE : OP_ALLOC;
      addr = (op == OP_FREE || $urandom_range(0, 1) == 0) ? pick_address()
                                                          : ADDR_BITS'($urandom);
      offer_request(op, addr);
    end
  endtask

  // corners under the reset defaults, then empty map, zero size, one block
  task automatic directed_corners_test();
    idle_enable = 1'b0;
    offer_request(OP_ALLOC, 32'h0000_0000);
    offer_request(OP_ALLOC, 32'hFFFF_FFFF);
    offer_request(OP_ALLOC, 32'h0000_0FFF);
    offer_request(OP_FREE,  32'd74);
    offer_request(OP_FREE,  32'd74);
    offer_request(OP_ALLOC, 32'h0000_0000);
    offer_request(OP_FREE,  32'd4095);
    offer_request(OP_FREE,  32'd4096);
    offer_request(OP_FREE,  32'hFFFF_FFFF);
    // no blocks at all
    drain_replies();
    write_register(REG_BLOCK_COUNT, 32'd0);
    offer_request(OP_ALLOC, 32'h0000_0000);
    offer_request(OP_FREE,  32'h0000_0000);
    // zero block size through masking of the upper data bits
    drain_replies();
    write_register(REG_BLOCK_COUNT, 32'd64);
    write_register(REG_BLOCK_SIZE, 32'h0002_0000);
    offer_request(OP_ALLOC, 32'h0000_0000);
    offer_request(OP_FREE,  32'h0000_0000);
    offer_request(OP_ALLOC, 32'h0000_0000);
    // unmapped index, then a single block at the top of the address space
    drain_replies();
    write_register(REG_SPARE, 32'hFFFF_FFFF);
    configure(32'hFFFF_FFFF, 32'd1, 32'd1);
    offer_request(OP_ALLOC, 32'hFFFF_FFFF);
    offer_request(OP_FREE,  32'hFFFF_FFFF);
    offer_request(OP_ALLOC, 32'h0000_0000);
    offer_request(OP_FREE,  32'h0000_0000);
  endtask

  // shrinking the count frees the blocks above it; oversize count saturates
  task automatic resize_clear_test();
    idle_enable = 1'b1;
    configure(32'h0000_1000, 32'd64, 32'd64);
    repeat (12) offer_request(OP_ALLOC, ADDR_BITS'($urandom));
    drain_replies();
    write_register(REG_BLOCK_COUNT, 32'd5);
    write_register(REG_BLOCK_COUNT, 32'd127);
    repeat (3) offer_request(OP_ALLOC, ADDR_BITS'($urandom));
    offer_request(OP_FREE, 32'h0000_1000 + 32'd64 * 32'd63 + 32'd63);
    offer_request(OP_FREE, 32'h0000_2000);
    offer_request(OP_FREE, 32'h0000_1040);
    offer_request(OP_ALLOC, 32'h0000_0FFF);
  endtask

  // random traffic across a spread of register settings
  task automatic random_settings_test();
    for (int phase = 0; phase < 8; phase++) begin
      idle_enable = (phase % 3 != 2);
      case (phase)
        0: configure(32'h0000_0000, 32'd1, 32'd64);
        1: configure(32'hFFFF_F000, 32'd256, 32'd64);
        2: configure($urandom, 32'h0001_0000, 32'd127);
        3: configure($urandom, $urandom_range(1, 65536), $urandom_range(1, 8));
        4: configure(32'hFFFF_FFFF, $urandom, $urandom_range(1, 64));
        5: configure($urandom, 32'h0002_0000, 32'd5);
        6: configure($urandom, 32'd3, 32'd0);
        default: configure($urandom, $urandom_range(1, 100), 32'd1);
      endcase
      run_traffic(PHASE_ITEMS, 30 + 15 * (phase % 3));
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic pressure_test();
    idle_enable = 1'b0;
    configure($urandom, 32'd16, 32'd64);
    hold_left = HOLD_OFF_CYCLES;
    run_traffic(40, 40);
  endtask

  // back to back beats on both sides, no idling
  task automatic steady_stream_test();
    idle_enable = 1'b0;
    configure($urandom, $urandom_range(1, 4096), $urandom_range(16, 64));
    run_traffic(200, 45);
  endtask

  // result side ready: long hold, random stall bursts, otherwise ready
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expected reply
  always @(posedge clk) begin : check_reply
    reply_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (replies_in_flight.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = replies_in_flight.pop_front();
        if (out_bus.status !== want.status)
          report_mismatch($sformatf("item %0d status %0d, expected %0d",
                                    want.seq, out_bus.status, want.status));
        if (out_bus.block_address !== want.block_address)
          report_mismatch($sformatf("item %0d block_address %h, expected %h",
                                    want.seq, out_bus.block_address, want.block_address));
        if (out_bus.in_region !== want.in_region)
          report_mismatch($sformatf("item %0d in_region %b, expected %b",
                                    want.seq, out_bus.in_region, want.in_region));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bitmap_block_allocator_core_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_ALLOC;
    in_bus.address   = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_HEAP_BASE;
    cfg_data         = '0;
    used_bits        = '0;
    base_addr        = RST_HEAP_BASE;
    blk_size         = RST_BLOCK_SIZE;
    blk_count        = RST_BLOCK_COUNT;
    request_seq      = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    hold_left        = 0;
    idle_enable      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_corners_test();
    resize_clear_test();
    random_settings_test();
    pressure_test();
    steady_stream_test();

    // wait out the last replies, then a quiet stretch for strays
    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (replies_in_flight.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", replies_in_flight.size()));
    if (error_count == 0) begin
      $display("bitmap_block_allocator_core_test: PASS");
    end else begin
      $display("bitmap_block_allocator_core_test: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_in_if.sv
hdl/bba_out_if.sv
hdl/bba_div.sv
hdl/bba_ctrl.sv
hdl/bba_dp.sv
hdl/bitmap_block_allocator_core.sv
test/bitmap_block_allocator_core_test.sv
